// ----- rtl/ats_pkg.sv -----
// ---------------------------------------------------------------------------
// ats_pkg
// Shared widths, point type, state encodings and status struct for the
// angular tolerance stroke simplifier.
// ---------------------------------------------------------------------------
package ats_pkg;

    // coordinate and tolerance formats
    localparam int COORD_BITS    = 16;
    localparam int TAN_W         = 16;
    localparam int TAN_FRAC_BITS = 12;
    localparam logic [TAN_W-1:0] TAN_RESET = TAN_W'(107);

    // stream word: x, y, z packed from the low bit, padded to whole bytes
    localparam int TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;

    // datapath widths
    localparam int DIFF_W = COORD_BITS + 1;                 // coordinate difference
    localparam int CD_W   = 2 * DIFF_W + 1;                 // cross or dot product
    localparam int MA_W   = CD_W + 1;                       // multiplier operand a
    localparam int MB_W   = ((DIFF_W > TAN_W) ? DIFF_W : TAN_W) + 1; // operand b
    localparam int MP_W   = MA_W + MB_W;                    // multiplier product

    // points seen in the current stroke
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BEND,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } top_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIFF,
        B_MUL0,
        B_MUL1,
        B_MUL2,
        B_MUL3,
        B_MUL4,
        B_CMP
    } bend_state_t;

    typedef struct packed {
        logic done;
        logic exceeds;
    } bend_stat_t;

endpackage

// ----- rtl/angular_tolerance_simplifier_top.sv -----
// ---------------------------------------------------------------------------
// angular_tolerance_simplifier_top
// Streaming angular tolerance simplification of a pen stroke: keeps the
// first point, every middle point that bends past the tolerance, and the
// final point of the stroke (marked with tlast).
// ---------------------------------------------------------------------------
// a first point is loaded from ST_EMIT_LAST into the output register, raising m_tvalid,
// once that register is free; a point that only fills the history is just accepted in ST_IDLE;
// once two points are held each word is accepted, then goes through the bend test
// (difference, four products, dot times tolerance, compare) and an emit state per kept point;
// s_tready stays low meanwhile and while m_tready holds a word back
// reset: tan_tolerance returns to 107, stroke state and the old and middle points clear
// ---------------------------------------------------------------------------
module angular_tolerance_simplifier_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ats_pkg::TDATA_W-1:0] s_tdata,   // pt_x, pt_y, pt_z
    input  logic                        s_tlast,   // end_of_stroke
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ats_pkg::TDATA_W-1:0] m_tdata,   // out_x, out_y, out_z
    output logic                        m_tlast,   // out_last
    // tolerance register
    input  logic                        cfg_we,
    input  logic [ats_pkg::TAN_W-1:0]   cfg_wdata
);

    ats_pkg::top_state_t  state_reg, state_next;
    logic [1:0]           seen_reg, seen_next;
    logic [ats_pkg::TAN_W-1:0] tan_reg;
    ats_pkg::point_t      old_reg, old_next;
    ats_pkg::point_t      mid_reg, mid_next;
    ats_pkg::point_t      cur_reg, cur_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    ats_pkg::point_t      out_pt_reg, out_pt_next;
    logic                 out_last_reg, out_last_next;

    ats_pkg::point_t      in_pt;
    ats_pkg::bend_stat_t  bend_st;
    logic                 s_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 bend_start;

    // unpack the input word
    assign in_pt.x = s_tdata[ats_pkg::COORD_BITS-1:0];
    assign in_pt.y = s_tdata[2*ats_pkg::COORD_BITS-1:ats_pkg::COORD_BITS];
    assign in_pt.z = s_tdata[3*ats_pkg::COORD_BITS-1:2*ats_pkg::COORD_BITS];

    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign bend_start = s_accept && (seen_reg == ats_pkg::SEEN_TWO);

    // output word
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = ats_pkg::TDATA_W'({out_pt_reg.z, out_pt_reg.y, out_pt_reg.x});

    // shared bend test
    ats_bend_unit u_bend (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (bend_start),
        .tan_tolerance (tan_reg),
        .p_old         (old_reg),
        .p_mid         (mid_reg),
        .p_cur         (cur_reg),
        .stat          (bend_st)
    );

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tan_reg <= ats_pkg::TAN_RESET;
        end
        else if (cfg_we)
        begin
            tan_reg <= cfg_wdata;
        end
    end

    // control and held points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ats_pkg::ST_IDLE;
            seen_reg      <= ats_pkg::SEEN_NONE;
            out_valid_reg <= 1'b0;
            old_reg       <= '0;
            mid_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            old_reg       <= old_next;
            mid_reg       <= mid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        last_reg     <= last_next;
        out_pt_reg   <= out_pt_next;
        out_last_reg <= out_last_next;
    end

    // stroke sequencer
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        old_next       = old_reg;
        mid_next       = mid_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        out_pt_next    = out_pt_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ats_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cur_next  = in_pt;
                    last_next = s_tlast;
                    priority if (seen_reg == ats_pkg::SEEN_TWO)
                    begin
                        seen_next  = s_tlast ? ats_pkg::SEEN_NONE : ats_pkg::SEEN_TWO;
                        state_next = ats_pkg::ST_BEND;
                    end
                    else if (seen_reg == ats_pkg::SEEN_ONE)
                    begin
                        mid_next   = in_pt;
                        seen_next  = s_tlast ? ats_pkg::SEEN_NONE : ats_pkg::SEEN_TWO;
                        state_next = s_tlast ? ats_pkg::ST_EMIT_LAST : ats_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // first point of a stroke is always sent
                        old_next   = in_pt;
                        seen_next  = s_tlast ? ats_pkg::SEEN_NONE : ats_pkg::SEEN_ONE;
                        state_next = ats_pkg::ST_EMIT_LAST;
                    end
                end
            end
            ats_pkg::ST_BEND:
            begin
                if (bend_st.done)
                begin
                    if (bend_st.exceeds)
                    begin
                        state_next = ats_pkg::ST_EMIT_MID;
                    end
                    else
                    begin
                        old_next   = mid_reg;
                        mid_next   = cur_reg;
                        state_next = last_reg ? ats_pkg::ST_EMIT_LAST : ats_pkg::ST_IDLE;
                    end
                end
            end
            ats_pkg::ST_EMIT_MID:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_pt_next   = mid_reg;
                    out_last_next = 1'b0;
                    old_next      = mid_reg;
                    mid_next      = cur_reg;
                    state_next    = last_reg ? ats_pkg::ST_EMIT_LAST : ats_pkg::ST_IDLE;
                end
            end
            ats_pkg::ST_EMIT_LAST:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_pt_next   = cur_reg;
                    out_last_next = last_reg;
                    state_next    = ats_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ats_pkg::ST_IDLE;
            end
        endcase

        // output register: load, drain or hold
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // stroke count never reaches the unused code
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= ats_pkg::SEEN_TWO)
        else $error("stroke point count out of range");

    // bend result only arrives while the sequencer waits for it
    a_bend_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        bend_st.done |-> (state_reg == ats_pkg::ST_BEND))
        else $error("bend result outside wait state");

    // first point of a stroke goes straight to output
    a_first_point: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (seen_reg == ats_pkg::SEEN_NONE)) |=> (state_reg == ats_pkg::ST_EMIT_LAST))
        else $error("first point of stroke not sent");

    // a word marked last leaves the block at the start of a stroke
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (seen_reg == ats_pkg::SEEN_NONE))
        else $error("stroke state not cleared after last word");

endmodule

// ----- rtl/ats_bend_unit.sv -----
// ---------------------------------------------------------------------------
// ats_bend_unit
// Bend test on one shared signed multiplier: forms cross and dot of
// old->mid and old->cur, then checks |cross| << 12 > |dot * tan_tolerance|.
// ---------------------------------------------------------------------------
module ats_bend_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ats_pkg::TAN_W-1:0] tan_tolerance,
    input  ats_pkg::point_t           p_old,
    input  ats_pkg::point_t           p_mid,
    input  ats_pkg::point_t           p_cur,
    output ats_pkg::bend_stat_t       stat
);

    ats_pkg::bend_state_t state_reg, state_next;

    logic signed [ats_pkg::DIFF_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [ats_pkg::DIFF_W-1:0] dx1_next, dy1_next, dx2_next, dy2_next;
    logic signed [ats_pkg::CD_W-1:0]   acc_reg, acc_next;
    logic signed [ats_pkg::CD_W-1:0]   cross_reg, cross_next;
    logic signed [ats_pkg::CD_W-1:0]   dot_reg, dot_next;
    logic        [ats_pkg::CD_W-1:0]   cmag_reg, cmag_next;
    logic signed [ats_pkg::MP_W-1:0]   prod_reg, prod_next;

    logic signed [ats_pkg::MA_W-1:0]   mul_a;
    logic signed [ats_pkg::MB_W-1:0]   mul_b;
    logic signed [ats_pkg::MP_W-1:0]   mul_p;
    logic        [ats_pkg::MP_W-1:0]   pmag;
    logic        [ats_pkg::MP_W-1:0]   lhs;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ats_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dx1_reg   <= dx1_next;
        dy1_reg   <= dy1_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        acc_reg   <= acc_next;
        cross_reg <= cross_next;
        dot_reg   <= dot_next;
        cmag_reg  <= cmag_next;
        prod_reg  <= prod_next;
    end

    // the one shared multiplier
    assign mul_p = mul_a * mul_b;

    // magnitudes for the final compare
    assign pmag = prod_reg[ats_pkg::MP_W-1] ? (~prod_reg + 1'b1) : prod_reg;
    assign lhs  = {{(ats_pkg::MP_W - ats_pkg::CD_W - ats_pkg::TAN_FRAC_BITS){1'b0}},
                   cmag_reg, {ats_pkg::TAN_FRAC_BITS{1'b0}}};

    // sequencer, operand selection and accumulation
    always_comb
    begin
        state_next   = state_reg;
        dx1_next     = dx1_reg;
        dy1_next     = dy1_reg;
        dx2_next     = dx2_reg;
        dy2_next     = dy2_reg;
        acc_next     = acc_reg;
        cross_next   = cross_reg;
        dot_next     = dot_reg;
        cmag_next    = cmag_reg;
        prod_next    = prod_reg;
        mul_a        = {{(ats_pkg::MA_W - ats_pkg::DIFF_W){dx1_reg[ats_pkg::DIFF_W-1]}}, dx1_reg};
        mul_b        = {{(ats_pkg::MB_W - ats_pkg::DIFF_W){dy2_reg[ats_pkg::DIFF_W-1]}}, dy2_reg};
        stat.done    = 1'b0;
        stat.exceeds = 1'b0;

        unique case (state_reg)
            ats_pkg::B_IDLE:
            begin
                if (start)
                begin
                    state_next = ats_pkg::B_DIFF;
                end
            end
            ats_pkg::B_DIFF:
            begin
                dx1_next   = {p_mid.x[ats_pkg::COORD_BITS-1], p_mid.x}
                           - {p_old.x[ats_pkg::COORD_BITS-1], p_old.x};
                dy1_next   = {p_mid.y[ats_pkg::COORD_BITS-1], p_mid.y}
                           - {p_old.y[ats_pkg::COORD_BITS-1], p_old.y};
                dx2_next   = {p_cur.x[ats_pkg::COORD_BITS-1], p_cur.x}
                           - {p_old.x[ats_pkg::COORD_BITS-1], p_old.x};
                dy2_next   = {p_cur.y[ats_pkg::COORD_BITS-1], p_cur.y}
                           - {p_old.y[ats_pkg::COORD_BITS-1], p_old.y};
                state_next = ats_pkg::B_MUL0;
            end
            ats_pkg::B_MUL0:
            begin
                // dx1 * dy2
                acc_next   = mul_p[ats_pkg::CD_W-1:0];
                state_next = ats_pkg::B_MUL1;
            end
            ats_pkg::B_MUL1:
            begin
                // cross = dx1 * dy2 - dy1 * dx2
                mul_a      = {{(ats_pkg::MA_W - ats_pkg::DIFF_W){dy1_reg[ats_pkg::DIFF_W-1]}},
                              dy1_reg};
                mul_b      = {{(ats_pkg::MB_W - ats_pkg::DIFF_W){dx2_reg[ats_pkg::DIFF_W-1]}},
                              dx2_reg};
                cross_next = acc_reg - mul_p[ats_pkg::CD_W-1:0];
                state_next = ats_pkg::B_MUL2;
            end
            ats_pkg::B_MUL2:
            begin
                // dx1 * dx2
                mul_b      = {{(ats_pkg::MB_W - ats_pkg::DIFF_W){dx2_reg[ats_pkg::DIFF_W-1]}},
                              dx2_reg};
                acc_next   = mul_p[ats_pkg::CD_W-1:0];
                state_next = ats_pkg::B_MUL3;
            end
            ats_pkg::B_MUL3:
            begin
                // dot = dx1 * dx2 + dy1 * dy2
                mul_a      = {{(ats_pkg::MA_W - ats_pkg::DIFF_W){dy1_reg[ats_pkg::DIFF_W-1]}},
                              dy1_reg};
                dot_next   = acc_reg + mul_p[ats_pkg::CD_W-1:0];
                state_next = ats_pkg::B_MUL4;
            end
            ats_pkg::B_MUL4:
            begin
                // dot * tolerance, cross magnitude alongside
                mul_a      = {{(ats_pkg::MA_W - ats_pkg::CD_W){dot_reg[ats_pkg::CD_W-1]}}, dot_reg};
                mul_b      = {{(ats_pkg::MB_W - ats_pkg::TAN_W){1'b0}}, tan_tolerance};
                prod_next  = mul_p;
                cmag_next  = cross_reg[ats_pkg::CD_W-1] ? (~cross_reg + 1'b1) : cross_reg;
                state_next = ats_pkg::B_CMP;
            end
            ats_pkg::B_CMP:
            begin
                stat.done    = 1'b1;
                stat.exceeds = (lhs > pmag);
                state_next   = ats_pkg::B_IDLE;
            end
            default:
            begin
                state_next = ats_pkg::B_IDLE;
            end
        endcase
    end

endmodule
